// File: sv/owtr_pkg.sv
// Package for the one-wire temperature reader.
// Holds the transfer payload types, command bytes, register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package owtr_pkg;

    typedef struct packed {
        logic start_req;
        logic line_level;
    } t_in;

    typedef struct packed {
        logic        drive_low;
        logic        busy_res;
        logic        presence_missing;
        logic        temperature_valid;
        logic [15:0] temperature;
    } t_out;

    localparam int CFG_DATA_BITS = 21;
    localparam int CFG_IDX_BITS  = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_RESET_LOW      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PRESENCE_WAIT  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RESET_RECOVERY = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SLOT_LOW       = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WRITE_HOLD     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_READ_SAMPLE    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_READ_TAIL      = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CONVERSION     = 3'd7;

    localparam logic [9:0]  RST_RESET_LOW      = 10'd500;
    localparam logic [7:0]  RST_PRESENCE_WAIT  = 8'd55;
    localparam logic [9:0]  RST_RESET_RECOVERY = 10'd400;
    localparam logic [3:0]  RST_SLOT_LOW       = 4'd6;
    localparam logic [6:0]  RST_WRITE_HOLD     = 7'd50;
    localparam logic [4:0]  RST_READ_SAMPLE    = 5'd8;
    localparam logic [6:0]  RST_READ_TAIL      = 7'd45;
    localparam logic [20:0] RST_CONVERSION     = 21'd1200000;

    localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
    localparam logic [7:0] CMD_CONVERT    = 8'h44;
    localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

    localparam logic [7:0] SLOT_RECOVERY = 8'd10;

endpackage
`default_nettype wire

// File: sv/onewire_temperature_reader.sv
// Top level of the one-wire temperature reader: bus sequencer and transfer handshake.
// Depends on owtr_pkg.
//
// Usage: every transfer on the input channel is one microsecond tick carrying
// start_req and the sampled bus level. Every accepted tick yields exactly one
// result transfer with drive_low (open-drain pull), busy_res, presence_missing,
// temperature_valid and the last temperature word. A start while idle runs
// reset/presence (retried until a device answers), skip-ROM and convert,
// the conversion wait, a second reset, skip-ROM, read-scratchpad and two read
// bytes; the word is then emitted with temperature_valid for one tick.
// The result is registered from the accepted input transfer. Throughput: one tick per
// cycle unless the receiver stalls, set by the single sequencer register stage. The
// result register accepts a new tick in the same cycle its held result is taken.
// When the receiver stalls, the result holds and o_in_stall rises so no tick
// is accepted until a slot frees up.
// Reset: the sequencer is idle, counters and the word are zero, the timing
// registers return to their default values and no result is pending.
// Timing registers are written through i_cfg_we/i_cfg_idx/i_cfg_data and apply
// when the next bus phase is entered.
`timescale 1ns / 1ps
`default_nettype none
module onewire_temperature_reader #(
    parameter int WAIT_COUNTER_BITS = 21
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  owtr_pkg::t_in                     i_in_data,
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output owtr_pkg::t_out                    o_out_data,
    input  wire                               i_cfg_we,
    input  wire [owtr_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire [owtr_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import owtr_pkg::*;

    localparam int W = WAIT_COUNTER_BITS;
    localparam int DB = 22;

    localparam logic [3:0] P_IDLE      = 4'd0;
    localparam logic [3:0] P_RST_LOW   = 4'd1;
    localparam logic [3:0] P_RST_WAIT  = 4'd2;
    localparam logic [3:0] P_RST_RECOV = 4'd3;
    localparam logic [3:0] P_WR_LOW    = 4'd4;
    localparam logic [3:0] P_WR_HOLD   = 4'd5;
    localparam logic [3:0] P_WR_REC    = 4'd6;
    localparam logic [3:0] P_RD_LOW    = 4'd7;
    localparam logic [3:0] P_RD_WAIT   = 4'd8;
    localparam logic [3:0] P_RD_TAIL   = 4'd9;
    localparam logic [3:0] P_CONV      = 4'd10;

    localparam logic [2:0] S_CONVERT   = 3'd0;
    localparam logic [2:0] S_CONV_SENT = 3'd1;
    localparam logic [2:0] S_CONV_WAIT = 3'd2;
    localparam logic [2:0] S_READ_CMD  = 3'd3;
    localparam logic [2:0] S_READ_SENT = 3'd4;
    localparam logic [2:0] S_LOW_BYTE  = 3'd5;
    localparam logic [2:0] S_HIGH_BYTE = 3'd6;

    logic [9:0]  r_reset_low;
    logic [7:0]  r_presence_wait;
    logic [9:0]  r_reset_recovery;
    logic [3:0]  r_slot_low;
    logic [6:0]  r_write_hold;
    logic [4:0]  r_read_sample;
    logic [6:0]  r_read_tail;
    logic [20:0] r_conversion;

    logic [3:0]   r_phase,   n_phase;
    logic [W-1:0] r_tc,      n_tc;
    logic [7:0]   r_shift,   n_shift;
    logic [2:0]   r_bit,     n_bit;
    logic [2:0]   r_step,    n_step;
    logic [7:0]   r_low,     n_low;
    logic [15:0]  r_word,    n_word;

    logic         r_out_valid;
    t_out         r_out, n_out;

    logic         accept;
    logic         enter;
    logic [3:0]   enter_phase;
    logic [DB-1:0] enter_dur;
    logic         go_idle;
    logic         byte_done;
    logic         last;

    function automatic logic [W-1:0] sat_dur(input logic [DB-1:0] d);
        logic [32:0] dext;
        logic [32:0] maxc;
        logic [32:0] r;
        dext = 33'(d);
        maxc = (33'(1) << W) - 33'(1);
        r = (dext > maxc) ? maxc : dext;
        if (r == 33'(0)) begin
            r = 33'(1);
        end
        return r[W-1:0];
    endfunction

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_phase     = r_phase;
        n_tc        = r_tc;
        n_shift     = r_shift;
        n_bit       = r_bit;
        n_step      = r_step;
        n_low       = r_low;
        n_word      = r_word;
        enter       = 1'b0;
        enter_phase = P_IDLE;
        enter_dur   = '0;
        go_idle     = 1'b0;
        byte_done   = 1'b0;
        last        = (r_tc <= W'(1));
        n_out       = '0;

        unique case (r_phase)
            P_RST_LOW, P_WR_LOW, P_RD_LOW: n_out.drive_low = 1'b1;
            P_WR_HOLD:                     n_out.drive_low = !r_shift[0];
            default:                       n_out.drive_low = 1'b0;
        endcase
        n_out.busy_res = (r_phase != P_IDLE);

        if (r_phase == P_IDLE) begin
            if (i_in_data.start_req) begin
                n_step      = S_CONVERT;
                enter       = 1'b1;
                enter_phase = P_RST_LOW;
                enter_dur   = DB'(r_reset_low);
            end
        end else begin
            if (!last) begin
                n_tc = r_tc - W'(1);
            end else begin
                unique case (r_phase)
                    P_RST_LOW: begin
                        enter       = 1'b1;
                        enter_phase = P_RST_WAIT;
                        enter_dur   = DB'(r_presence_wait);
                    end
                    P_RST_WAIT: begin
                        n_out.presence_missing = i_in_data.line_level;
                        n_shift     = {7'd0, i_in_data.line_level};
                        enter       = 1'b1;
                        enter_phase = P_RST_RECOV;
                        enter_dur   = DB'(r_reset_recovery);
                    end
                    P_RST_RECOV: begin
                        if (r_shift[0]) begin
                            enter       = 1'b1;
                            enter_phase = P_RST_LOW;
                            enter_dur   = DB'(r_reset_low);
                        end else if (r_step == S_CONVERT || r_step == S_READ_CMD) begin
                            n_shift     = CMD_SKIP_ROM;
                            n_bit       = 3'd0;
                            enter       = 1'b1;
                            enter_phase = P_WR_LOW;
                            enter_dur   = DB'(r_slot_low);
                        end else begin
                            go_idle = 1'b1;
                        end
                    end
                    P_WR_LOW: begin
                        enter       = 1'b1;
                        enter_phase = P_WR_HOLD;
                        enter_dur   = DB'(r_write_hold);
                    end
                    P_WR_HOLD: begin
                        enter       = 1'b1;
                        enter_phase = P_WR_REC;
                        enter_dur   = DB'(SLOT_RECOVERY);
                    end
                    P_WR_REC: begin
                        n_shift = r_shift >> 1;
                        if (r_bit == 3'd7) begin
                            byte_done = 1'b1;
                        end else begin
                            n_bit       = r_bit + 3'd1;
                            enter       = 1'b1;
                            enter_phase = P_WR_LOW;
                            enter_dur   = DB'(r_slot_low);
                        end
                    end
                    P_RD_LOW: begin
                        enter       = 1'b1;
                        enter_phase = P_RD_WAIT;
                        enter_dur   = DB'(r_read_sample);
                    end
                    P_RD_WAIT: begin
                        n_shift     = {i_in_data.line_level, r_shift[7:1]};
                        enter       = 1'b1;
                        enter_phase = P_RD_TAIL;
                        enter_dur   = DB'(r_read_tail) + DB'(SLOT_RECOVERY);
                    end
                    P_RD_TAIL: begin
                        if (r_bit == 3'd7) begin
                            byte_done = 1'b1;
                        end else begin
                            n_bit       = r_bit + 3'd1;
                            enter       = 1'b1;
                            enter_phase = P_RD_LOW;
                            enter_dur   = DB'(r_slot_low);
                        end
                    end
                    P_CONV: begin
                        n_step      = S_READ_CMD;
                        enter       = 1'b1;
                        enter_phase = P_RST_LOW;
                        enter_dur   = DB'(r_reset_low);
                    end
                    default: go_idle = 1'b1;
                endcase

                if (byte_done) begin
                    unique case (r_step)
                        S_CONVERT: begin
                            n_step      = S_CONV_SENT;
                            n_shift     = CMD_CONVERT;
                            n_bit       = 3'd0;
                            enter       = 1'b1;
                            enter_phase = P_WR_LOW;
                            enter_dur   = DB'(r_slot_low);
                        end
                        S_CONV_SENT: begin
                            n_step      = S_CONV_WAIT;
                            enter       = 1'b1;
                            enter_phase = P_CONV;
                            enter_dur   = DB'(r_conversion);
                        end
                        S_READ_CMD: begin
                            n_step      = S_READ_SENT;
                            n_shift     = CMD_READ_SCRATCH;
                            n_bit       = 3'd0;
                            enter       = 1'b1;
                            enter_phase = P_WR_LOW;
                            enter_dur   = DB'(r_slot_low);
                        end
                        S_READ_SENT: begin
                            n_step      = S_LOW_BYTE;
                            n_shift     = 8'd0;
                            n_bit       = 3'd0;
                            enter       = 1'b1;
                            enter_phase = P_RD_LOW;
                            enter_dur   = DB'(r_slot_low);
                        end
                        S_LOW_BYTE: begin
                            n_low       = n_shift;
                            n_step      = S_HIGH_BYTE;
                            n_shift     = 8'd0;
                            n_bit       = 3'd0;
                            enter       = 1'b1;
                            enter_phase = P_RD_LOW;
                            enter_dur   = DB'(r_slot_low);
                        end
                        S_HIGH_BYTE: begin
                            n_word = {n_shift, r_low};
                            n_out.temperature_valid = 1'b1;
                            go_idle = 1'b1;
                        end
                        default: go_idle = 1'b1;
                    endcase
                end
            end
        end

        if (enter) begin
            n_phase = enter_phase;
            n_tc    = sat_dur(enter_dur);
        end
        if (go_idle) begin
            n_phase = P_IDLE;
            n_tc    = '0;
            n_step  = S_CONVERT;
        end
        n_out.temperature = n_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reset_low      <= RST_RESET_LOW;
            r_presence_wait  <= RST_PRESENCE_WAIT;
            r_reset_recovery <= RST_RESET_RECOVERY;
            r_slot_low       <= RST_SLOT_LOW;
            r_write_hold     <= RST_WRITE_HOLD;
            r_read_sample    <= RST_READ_SAMPLE;
            r_read_tail      <= RST_READ_TAIL;
            r_conversion     <= RST_CONVERSION;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RESET_LOW:      r_reset_low      <= i_cfg_data[9:0];
                CFG_PRESENCE_WAIT:  r_presence_wait  <= i_cfg_data[7:0];
                CFG_RESET_RECOVERY: r_reset_recovery <= i_cfg_data[9:0];
                CFG_SLOT_LOW:       r_slot_low       <= i_cfg_data[3:0];
                CFG_WRITE_HOLD:     r_write_hold     <= i_cfg_data[6:0];
                CFG_READ_SAMPLE:    r_read_sample    <= i_cfg_data[4:0];
                CFG_READ_TAIL:      r_read_tail      <= i_cfg_data[6:0];
                CFG_CONVERSION:     r_conversion     <= i_cfg_data[20:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= P_IDLE;
            r_tc        <= '0;
            r_shift     <= '0;
            r_bit       <= '0;
            r_step      <= S_CONVERT;
            r_low       <= '0;
            r_word      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase     <= n_phase;
                r_tc        <= n_tc;
                r_shift     <= n_shift;
                r_bit       <= n_bit;
                r_step      <= n_step;
                r_low       <= n_low;
                r_word      <= n_word;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire

// File: tb/sv/onewire_temperature_reader_tb.sv
`timescale 1ns / 1ps
// Testbench for onewire_temperature_reader: random tick stream from a simple bus device
// model, checked tick by tick against a bus master model kept in a scoreboard class.
// Depends on owtr_pkg and the onewire_temperature_reader RTL.
module onewire_temperature_reader_tb;
    import owtr_pkg::*;

    localparam int          WAIT_BITS  = 21;
    localparam int unsigned WAIT_MAX   = (1 << WAIT_BITS) - 1;
    localparam int          NUM_REGS   = 1 << CFG_IDX_BITS;
    localparam int          IDLE_LIMIT = 2000;
    localparam int          LONG_HOLD  = 300;

    typedef enum logic [3:0] {
        PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_RECOV, PH_WR_LOW, PH_WR_HOLD,
        PH_WR_REC, PH_RD_LOW, PH_RD_WAIT, PH_RD_TAIL, PH_CONV
    } t_bus_phase;

    typedef enum logic [2:0] {
        SEQ_SKIP_CONV, SEQ_CONVERT, SEQ_CONV_WAIT, SEQ_SKIP_READ, SEQ_READ_CMD,
        SEQ_LOW_BYTE, SEQ_HIGH_BYTE
    } t_seq_step;

    class t_reader_scoreboard;
        t_bus_phase           phase;
        logic [WAIT_BITS-1:0] remaining;
        logic [7:0]           shreg;
        logic [2:0]           bit_idx;
        t_seq_step            step;
        logic [7:0]           low_byte;
        logic [15:0]          word;
        int unsigned          timing [NUM_REGS];
        t_out                 expected_ticks [$];
        int                   errors;

        function new();
            timing[CFG_RESET_LOW]      = RST_RESET_LOW;
            timing[CFG_PRESENCE_WAIT]  = RST_PRESENCE_WAIT;
            timing[CFG_RESET_RECOVERY] = RST_RESET_RECOVERY;
            timing[CFG_SLOT_LOW]       = RST_SLOT_LOW;
            timing[CFG_WRITE_HOLD]     = RST_WRITE_HOLD;
            timing[CFG_READ_SAMPLE]    = RST_READ_SAMPLE;
            timing[CFG_READ_TAIL]      = RST_READ_TAIL;
            timing[CFG_CONVERSION]     = RST_CONVERSION;
            phase      = PH_IDLE;
            remaining  = '0;
            shreg      = '0;
            bit_idx    = '0;
            step       = SEQ_SKIP_CONV;
            low_byte   = '0;
            word       = '0;
            errors     = 0;
        endfunction

        function int unsigned field_mask(logic [CFG_IDX_BITS-1:0] idx);
            case (idx)
                CFG_RESET_LOW, CFG_RESET_RECOVERY: return 'h3FF;
                CFG_PRESENCE_WAIT: return 'hFF;
                CFG_SLOT_LOW: return 'hF;
                CFG_WRITE_HOLD, CFG_READ_TAIL: return 'h7F;
                CFG_READ_SAMPLE: return 'h1F;
                default: return 'h1FFFFF;
            endcase
        endfunction

        function void write_timing(logic [CFG_IDX_BITS-1:0] idx, int unsigned data);
            timing[idx] = data & field_mask(idx);
        endfunction

        function void load(t_bus_phase next, int unsigned dur);
            if (dur > WAIT_MAX) dur = WAIT_MAX;
            if (dur == 0) dur = 1;
            phase     = next;
            remaining = dur[WAIT_BITS-1:0];
        endfunction

        function void begin_write(logic [7:0] cmd);
            shreg   = cmd;
            bit_idx = '0;
            load(PH_WR_LOW, timing[CFG_SLOT_LOW]);
        endfunction

        function void begin_read();
            shreg   = '0;
            bit_idx = '0;
            load(PH_RD_LOW, timing[CFG_SLOT_LOW]);
        endfunction

        function void go_idle();
            phase     = PH_IDLE;
            remaining = '0;
            step      = SEQ_SKIP_CONV;
        endfunction

        function bit finish_byte();
            case (step)
                SEQ_SKIP_CONV: begin
                    step = SEQ_CONVERT;
                    begin_write(CMD_CONVERT);
                end
                SEQ_CONVERT: begin
                    step = SEQ_CONV_WAIT;
                    load(PH_CONV, timing[CFG_CONVERSION]);
                end
                SEQ_SKIP_READ: begin
                    step = SEQ_READ_CMD;
                    begin_write(CMD_READ_SCRATCH);
                end
                SEQ_READ_CMD: begin
                    step = SEQ_LOW_BYTE;
                    begin_read();
                end
                SEQ_LOW_BYTE: begin
                    low_byte = shreg;
                    step     = SEQ_HIGH_BYTE;
                    begin_read();
                end
                SEQ_HIGH_BYTE: begin
                    word = {shreg, low_byte};
                    go_idle();
                    return 1'b1;
                end
                default: go_idle();
            endcase
            return 1'b0;
        endfunction

        function t_out advance_bus_master(t_in tick);
            t_out r;
            bit   last;
            r          = '0;
            r.busy_res = (phase != PH_IDLE);
            case (phase)
                PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: r.drive_low = 1'b1;
                PH_WR_HOLD: r.drive_low = ~shreg[0];
                default: r.drive_low = 1'b0;
            endcase
            if (phase == PH_IDLE) begin
                if (tick.start_req) begin
                    step = SEQ_SKIP_CONV;
                    load(PH_RST_LOW, timing[CFG_RESET_LOW]);
                end
            end else begin
                last = (remaining <= 1);
                if (!last) remaining = remaining - 1'b1;
                if (last) begin
                    case (phase)
                        PH_RST_LOW: load(PH_RST_WAIT, timing[CFG_PRESENCE_WAIT]);
                        PH_RST_WAIT: begin
                            r.presence_missing = tick.line_level;
                            shreg = {7'd0, tick.line_level};
                            load(PH_RST_RECOV, timing[CFG_RESET_RECOVERY]);
                        end
                        PH_RST_RECOV: begin
                            if (shreg[0]) load(PH_RST_LOW, timing[CFG_RESET_LOW]);
                            else if (step == SEQ_SKIP_CONV || step == SEQ_SKIP_READ)
                                begin_write(CMD_SKIP_ROM);
                            else go_idle();
                        end
                        PH_WR_LOW: load(PH_WR_HOLD, timing[CFG_WRITE_HOLD]);
                        PH_WR_HOLD: load(PH_WR_REC, SLOT_RECOVERY);
                        PH_WR_REC: begin
                            shreg = shreg >> 1;
                            if (bit_idx == 3'd7) r.temperature_valid = finish_byte();
                            else begin
                                bit_idx++;
                                load(PH_WR_LOW, timing[CFG_SLOT_LOW]);
                            end
                        end
                        PH_RD_LOW: load(PH_RD_WAIT, timing[CFG_READ_SAMPLE]);
                        PH_RD_WAIT: begin
                            shreg = {tick.line_level, shreg[7:1]};
                            load(PH_RD_TAIL, timing[CFG_READ_TAIL] + SLOT_RECOVERY);
                        end
                        PH_RD_TAIL: begin
                            if (bit_idx == 3'd7) r.temperature_valid = finish_byte();
                            else begin
                                bit_idx++;
                                load(PH_RD_LOW, timing[CFG_SLOT_LOW]);
                            end
                        end
                        PH_CONV: begin
                            step = SEQ_SKIP_READ;
                            load(PH_RST_LOW, timing[CFG_RESET_LOW]);
                        end
                        default: go_idle();
                    endcase
                end
            end
            r.temperature = word;
            return r;
        endfunction

        function void note_tick(t_in tick);
            expected_ticks.push_back(advance_bus_master(tick));
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (expected_ticks.size() == 0) begin
                $error("result transfer with no tick outstanding: %h", got);
                errors++;
                return;
            end
            want = expected_ticks.pop_front();
            if ($isunknown(got)) begin
                $error("result has unknown bits: expected %h, got %h", want, got);
                errors++;
                return;
            end
            compare_field("drive_low", want.drive_low, got.drive_low);
            compare_field("busy_res", want.busy_res, got.busy_res);
            compare_field("presence_missing", want.presence_missing, got.presence_missing);
            compare_field("temperature_valid", want.temperature_valid, got.temperature_valid);
            compare_field("temperature", want.temperature, got.temperature);
        endfunction
    endclass

    t_reader_scoreboard sb = new();

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    t_in                      in_data   = '0;
    logic                     in_stall;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    t_out                     out_data;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

    int          burst_left    = 0;
    bit          draining      = 1'b0;
    bit          long_hold_req = 1'b0;
    bit          junk_upper    = 1'b0;
    logic [15:0] device_word   = '0;
    int unsigned plan [NUM_REGS];
    int          idle_cycles   = 0;

    onewire_temperature_reader #(
        .WAIT_COUNTER_BITS(WAIT_BITS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && !out_stall) sb.check_result(out_data);
    end

    always @(posedge clk) begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int hold_left;
        int window_left;
        int stall_pct;
        hold_left   = 0;
        window_left = 0;
        stall_pct   = 0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD - 1;
                out_stall     <= 1'b1;
            end else begin
                if (window_left == 0) begin
                    window_left = $urandom_range(10, 150);
                    case ($urandom_range(0, 2))
                        0: stall_pct = 0;
                        1: stall_pct = 50;
                        default: stall_pct = 80;
                    endcase
                end
                window_left--;
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    task set_plan(input int unsigned rst_low, pres_wait, rst_recov, slot_low,
                  wr_hold, rd_sample, rd_tail, conv_wait);
        plan[CFG_RESET_LOW]      = rst_low;
        plan[CFG_PRESENCE_WAIT]  = pres_wait;
        plan[CFG_RESET_RECOVERY] = rst_recov;
        plan[CFG_SLOT_LOW]       = slot_low;
        plan[CFG_WRITE_HOLD]     = wr_hold;
        plan[CFG_READ_SAMPLE]    = rd_sample;
        plan[CFG_READ_TAIL]      = rd_tail;
        plan[CFG_CONVERSION]     = conv_wait;
    endtask

    task program_timing();
        for (int i = 0; i < NUM_REGS; i++) begin
            logic [CFG_IDX_BITS-1:0]  idx;
            logic [CFG_DATA_BITS-1:0] data;
            idx  = i[CFG_IDX_BITS-1:0];
            data = plan[idx][CFG_DATA_BITS-1:0];
            if (junk_upper)
                data = data | (CFG_DATA_BITS'($urandom) & ~CFG_DATA_BITS'(sb.field_mask(idx)));
            cfg_we   <= 1'b1;
            cfg_idx  <= idx;
            cfg_data <= data;
            @(posedge clk);
            sb.write_timing(idx, data);
        end
        cfg_we <= 1'b0;
    endtask

    task send_tick(input t_in tick);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 60);
            if ($urandom_range(0, 3) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= tick;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_tick(tick);
    endtask

    // answer presence most of the time, return the device word on read samples
    task make_tick(output t_in tick);
        tick.start_req = (sb.phase == PH_IDLE) ? (!draining && $urandom_range(0, 9) == 0)
                                               : ($urandom_range(0, 1) == 1);
        if (sb.phase == PH_IDLE && tick.start_req) begin
            case ($urandom_range(0, 3))
                0: device_word = 16'h0000;
                1: device_word = 16'hFFFF;
                default: device_word = 16'($urandom);
            endcase
        end
        case (sb.phase)
            PH_RST_WAIT: tick.line_level = ($urandom_range(0, 7) == 0);
            PH_RD_WAIT: tick.line_level = device_word[{sb.step == SEQ_HIGH_BYTE, sb.bit_idx}];
            default: tick.line_level = $urandom_range(0, 1);
        endcase
    endtask

    task quiesce();
        in_valid   <= 1'b0;
        burst_left = 0;
        while (sb.expected_ticks.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial begin
        t_in         tick;
        int unsigned round_ticks;
        int unsigned round;
        bit          pressed;
        bit          open_start [12] = '{1, 1, 0, 0, 1, 0, 1, 0, 0, 0, 1, 0};
        bit          open_line  [12] = '{1, 0, 1, 0, 1, 1, 1, 1, 0, 1, 0, 1};

        while (rst_n !== 1'b1) @(posedge clk);

        // idle ticks under the reset timing, then under the widest timing
        send_tick('{start_req: 1'b0, line_level: 1'b0});
        send_tick('{start_req: 1'b0, line_level: 1'b1});
        quiesce();
        set_plan(1023, 255, 1023, 15, 127, 31, 127, 2097151);
        program_timing();
        send_tick('{start_req: 1'b0, line_level: 1'b1});
        send_tick('{start_req: 1'b0, line_level: 0});
        quiesce();

        // zero durations: missing presence twice, start while busy, then the first slot
        device_word = 16'($urandom);
        set_plan(0, 0, 0, 1, 0, 0, 0, 0);
        program_timing();
        for (int i = 0; i < 12; i++)
            send_tick('{start_req: open_start[i], line_level: open_line[i]});
        quiesce();

        // finish the sequence, retiming the bus between short stretches of ticks
        draining = 1'b1;
        round    = 0;
        pressed  = 1'b0;
        while (sb.phase != PH_IDLE) begin
            junk_upper = round[0];
            if (round[0])
                set_plan($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3),
                         $urandom_range(1, 2), $urandom_range(0, 1), $urandom_range(0, 2),
                         $urandom_range(0, 1), $urandom_range(0, 4));
            else
                set_plan(0, 0, 0, 1, 0, 0, 0, 0);
            program_timing();
            round_ticks = 0;
            while (sb.phase != PH_IDLE && round_ticks < 64) begin
                make_tick(tick);
                send_tick(tick);
                round_ticks++;
                if (!pressed && round_ticks == 40) begin
                    long_hold_req = 1'b1;
                    pressed       = 1'b1;
                end
            end
            quiesce();
            round++;
        end
        draining = 1'b0;

        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
sv/owtr_pkg.sv
sv/onewire_temperature_reader.sv
tb/sv/onewire_temperature_reader_tb.sv
